/* design/bchc_pkg.sv */
package bchc_pkg;

  localparam int BUTTON_SLOTS_DEF = 4;
  localparam int RAW_W            = 4;
  localparam int IDX_W            = 2;
  localparam int CODE_W           = 8;
  localparam int CNT_W            = 8;
  localparam int TMR_W            = 16;
  localparam int MAX_REPORTS      = 8;

  localparam int HOLD_STEP_UNIT   = 5;
  localparam int HOLD_STEPS_MAX   = 65535;
  localparam int HOLD_Q_MAX       = HOLD_STEPS_MAX / HOLD_STEP_UNIT;
  localparam int HOLD_Q_W         = $clog2(HOLD_Q_MAX + 1);
  localparam int HOLD_R_W         = $clog2(HOLD_STEP_UNIT);

  localparam int NUM_REGS         = 7;
  localparam int APB_AW           = $clog2(4 * NUM_REGS);
  localparam int APB_DW           = 32;

  typedef enum logic [2:0] {
    REG_DEBOUNCE      = 3'd0,
    REG_PRESS_LEVEL   = 3'd1,
    REG_HOLD_PERIOD   = 3'd2,
    REG_RELEASE_DELAY = 3'd3,
    REG_PRESS_LIMIT   = 3'd4,
    REG_HOLD_LIMIT    = 3'd5,
    REG_UNKNOWN_CODE  = 3'd6
  } reg_idx_t;

  typedef enum logic {
    KIND_HOLD  = 1'b0,
    KIND_FINAL = 1'b1
  } report_kind_t;

  typedef struct packed {
    logic [CNT_W-1:0]  debounce_count;
    logic              press_level;
    logic [TMR_W-1:0]  hold_period_ticks;
    logic [TMR_W-1:0]  release_delay_ticks;
    logic [CNT_W-1:0]  press_limit;
    logic [CNT_W-1:0]  hold_limit;
    logic [CODE_W-1:0] unknown_code;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    debounce_count:      8'd5,
    press_level:         1'b0,
    hold_period_ticks:   16'd200,
    release_delay_ticks: 16'd500,
    press_limit:         8'd5,
    hold_limit:          8'd10,
    unknown_code:        8'd255
  };

  // released pin level under the reset press polarity
  localparam logic IDLE_LEVEL_RST = 1'b1;

endpackage

/* design/bchc_if.sv */
interface bchc_in_if;
  import bchc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink   (input valid, input raw_levels, output ready);
endinterface

interface bchc_out_if;
  import bchc_pkg::*;

  logic              valid;
  logic              ready;
  logic              report_kind;
  logic [IDX_W-1:0]  button_index;
  logic [CODE_W-1:0] report_code;
  logic              last;

  modport source (output valid, output report_kind, output button_index, output report_code,
                  output last, input ready);
  modport sink   (input valid, input report_kind, input button_index, input report_code,
                  input last, output ready);
endinterface

/* design/button_click_hold_classifier.sv */
// Button click/hold classifier. Each accepted word is one tick of raw pin levels;
// the tick is registered, then debounce, hold timer, release timer and the per-button
// click/hold state are all updated together, and the reports it causes (hold
// progress first, then final reports, each in button order, at most 8) are queued and
// sent one per cycle, while the receiver is ready, through a single output register. A
// tick that causes reports holds the next tick in the input register until the last of
// them has moved into the output register.
// Ticks are accepted while the previous reports are still waiting on the output.
module button_click_hold_classifier #(
  parameter int BUTTON_SLOTS = bchc_pkg::BUTTON_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bchc_in_if.sink                     in_ch,
  bchc_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bchc_pkg::APB_AW-1:0] paddr,
  input  logic [bchc_pkg::APB_DW-1:0] pwdata,
  output logic [bchc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import bchc_pkg::*;

  localparam int NSLOT = 2 * BUTTON_SLOTS;
  localparam int EXT_W = (BUTTON_SLOTS > RAW_W) ? BUTTON_SLOTS : RAW_W;

  cfg_t cfg;

  logic             inreg_v_r;
  logic [RAW_W-1:0] raw_r;
  logic [EXT_W-1:0] raw_ext;
  logic             batch_free;
  logic             advance;

  logic [BUTTON_SLOTS-1:0] cand_r, cand_nxt;
  logic [BUTTON_SLOTS-1:0] acc_r, acc_nxt;
  logic [BUTTON_SLOTS-1:0] down_r, down_nxt;
  logic [BUTTON_SLOTS-1:0] rel_r, rel_nxt;
  logic [BUTTON_SLOTS-1:0] holding_r, holding_nxt;
  logic [CNT_W-1:0]        stable_r [BUTTON_SLOTS];
  logic [CNT_W-1:0]        stable_nxt [BUTTON_SLOTS];
  logic [CNT_W-1:0]        click_r [BUTTON_SLOTS];
  logic [CNT_W-1:0]        click_nxt [BUTTON_SLOTS];
  logic [HOLD_Q_W-1:0]     hq_r [BUTTON_SLOTS];
  logic [HOLD_Q_W-1:0]     hq_nxt [BUTTON_SLOTS];
  logic [HOLD_R_W-1:0]     hr_r [BUTTON_SLOTS];
  logic [HOLD_R_W-1:0]     hr_nxt [BUTTON_SLOTS];
  logic [TMR_W-1:0]        hold_cnt_r, hold_cnt_nxt;
  logic [TMR_W-1:0]        rel_cnt_r, rel_cnt_nxt;
  logic                    hold_arm_r, hold_arm_nxt;
  logic                    rel_arm_r, rel_arm_nxt;

  logic                    hold_fire;
  logic                    rel_fire;
  logic [HOLD_Q_W:0]       hsum;
  logic [NSLOT-1:0]        rpt_raw;
  logic [NSLOT-1:0]        rpt_mask;
  logic [NSLOT-1:0]        pre;
  logic [CODE_W-1:0]       rpt_code [NSLOT];

  // hold steps are kept as quotient and remainder by the step unit
  function automatic logic [HOLD_Q_W:0] hold_code(input logic [HOLD_Q_W-1:0] q,
                                                  input logic [CNT_W-1:0]    lim);
    return {1'b0, q} + (HOLD_Q_W + 1)'(lim);
  endfunction

  bchc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = !inreg_v_r || batch_free;
  assign advance     = inreg_v_r && batch_free;
  assign raw_ext     = EXT_W'(raw_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inreg_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      inreg_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      raw_r <= in_ch.raw_levels;
    end
  end

  always_comb begin
    cand_nxt    = cand_r;
    acc_nxt     = acc_r;
    down_nxt    = down_r;
    rel_nxt     = rel_r;
    holding_nxt = holding_r;
    stable_nxt  = stable_r;
    click_nxt   = click_r;
    hq_nxt      = hq_r;
    hr_nxt      = hr_r;
    hsum        = '0;
    rpt_raw     = '0;
    for (int k = 0; k < NSLOT; k++) begin
      rpt_code[k] = '0;
    end

    // hold timer
    hold_fire    = hold_arm_r && (hold_cnt_r <= TMR_W'(1));
    hold_arm_nxt = hold_arm_r && !hold_fire;
    hold_cnt_nxt = hold_fire ? '0 : (hold_arm_r ? hold_cnt_r - TMR_W'(1) : hold_cnt_r);
    for (int i = 0; i < BUTTON_SLOTS; i++) begin
      if (hold_fire && down_r[i]) begin
        if (!((hq_r[i] == HOLD_Q_W'(HOLD_Q_MAX)) && (hr_r[i] == '0))) begin
          if (hr_r[i] == HOLD_R_W'(HOLD_STEP_UNIT - 1)) begin
            hr_nxt[i] = '0;
            hq_nxt[i] = hq_r[i] + HOLD_Q_W'(1);
          end else begin
            hr_nxt[i] = hr_r[i] + HOLD_R_W'(1);
          end
        end
        if (hq_nxt[i] != '0) begin
          holding_nxt[i] = 1'b1;
          click_nxt[i]   = '0;
        end
        if (hr_nxt[i] == '0) begin
          hsum        = hold_code(hq_nxt[i], cfg.press_limit);
          rpt_raw[i]  = 1'b1;
          rpt_code[i] = (hsum > (HOLD_Q_W + 1)'({CODE_W{1'b1}})) ? '1 : hsum[CODE_W-1:0];
        end
      end
    end
    if (hold_fire && (down_r != '0)) begin
      hold_arm_nxt = 1'b1;
      hold_cnt_nxt = (cfg.hold_period_ticks == '0) ? TMR_W'(1) : cfg.hold_period_ticks;
    end

    // release timer and final reports
    rel_fire    = rel_arm_r && (rel_cnt_r <= TMR_W'(1));
    rel_arm_nxt = rel_arm_r && !rel_fire;
    rel_cnt_nxt = rel_fire ? '0 : (rel_arm_r ? rel_cnt_r - TMR_W'(1) : rel_cnt_r);
    for (int i = 0; i < BUTTON_SLOTS; i++) begin
      if (rel_fire && rel_r[i]) begin
        if (!holding_nxt[i]) begin
          rpt_code[BUTTON_SLOTS + i] = (click_nxt[i] >= cfg.press_limit) ?
                                       cfg.unknown_code : click_nxt[i];
        end else begin
          hsum = hold_code(hq_nxt[i], cfg.press_limit);
          rpt_code[BUTTON_SLOTS + i] = (hsum >= (HOLD_Q_W + 1)'(cfg.hold_limit)) ?
                                       cfg.unknown_code : hsum[CODE_W-1:0];
        end
        rpt_raw[BUTTON_SLOTS + i] = 1'b1;
        hq_nxt[i]      = '0;
        hr_nxt[i]      = '0;
        click_nxt[i]   = '0;
        down_nxt[i]    = 1'b0;
        rel_nxt[i]     = 1'b0;
        holding_nxt[i] = 1'b0;
      end
    end

    // debounce, press and release
    for (int i = 0; i < BUTTON_SLOTS; i++) begin
      if (raw_ext[i] != cand_r[i]) begin
        cand_nxt[i]   = raw_ext[i];
        stable_nxt[i] = CNT_W'(1);
      end else if (stable_r[i] != '1) begin
        stable_nxt[i] = stable_r[i] + CNT_W'(1);
      end
      if ((stable_nxt[i] >= cfg.debounce_count) && (cand_nxt[i] != acc_r[i])) begin
        acc_nxt[i] = cand_nxt[i];
        if (cand_nxt[i] == cfg.press_level) begin
          if (click_nxt[i] != '1) begin
            click_nxt[i] = click_nxt[i] + CNT_W'(1);
          end
          if (!down_nxt[i]) begin
            hold_arm_nxt = 1'b1;
            hold_cnt_nxt = TMR_W'(1);
          end
          holding_nxt[i] = 1'b0;
          hq_nxt[i]      = '0;
          hr_nxt[i]      = '0;
          down_nxt[i]    = 1'b1;
          rel_nxt[i]     = 1'b0;
        end else begin
          rel_nxt[i]  = 1'b1;
          down_nxt[i] = 1'b0;
          rel_arm_nxt = 1'b1;
          rel_cnt_nxt = (cfg.release_delay_ticks == '0) ? TMR_W'(1) :
                        cfg.release_delay_ticks;
        end
      end
    end
  end

  // per-tick report cap
  always_comb begin
    pre      = '0;
    rpt_mask = '0;
    for (int k = 0; k < NSLOT; k++) begin
      for (int j = 0; j < NSLOT; j++) begin
        pre[j] = (j < k) && rpt_raw[j];
      end
      rpt_mask[k] = rpt_raw[k] && ($countones(pre) < MAX_REPORTS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r     <= {BUTTON_SLOTS{IDLE_LEVEL_RST}};
      acc_r      <= {BUTTON_SLOTS{IDLE_LEVEL_RST}};
      down_r     <= '0;
      rel_r      <= '0;
      holding_r  <= '0;
      for (int i = 0; i < BUTTON_SLOTS; i++) begin
        stable_r[i] <= '0;
        click_r[i]  <= '0;
        hq_r[i]     <= '0;
        hr_r[i]     <= '0;
      end
      hold_cnt_r <= '0;
      rel_cnt_r  <= '0;
      hold_arm_r <= 1'b0;
      rel_arm_r  <= 1'b0;
    end else if (advance) begin
      cand_r     <= cand_nxt;
      acc_r      <= acc_nxt;
      down_r     <= down_nxt;
      rel_r      <= rel_nxt;
      holding_r  <= holding_nxt;
      stable_r   <= stable_nxt;
      click_r    <= click_nxt;
      hq_r       <= hq_nxt;
      hr_r       <= hr_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      rel_cnt_r  <= rel_cnt_nxt;
      hold_arm_r <= hold_arm_nxt;
      rel_arm_r  <= rel_arm_nxt;
    end
  end

  bchc_ser #(
    .BUTTON_SLOTS (BUTTON_SLOTS)
  ) u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .load_mask (rpt_mask),
    .load_code (rpt_code),
    .free      (batch_free),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_arm_r |-> (hold_cnt_r == '0))
    else $error("hold countdown nonzero while disarmed");

  a_rel_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !rel_arm_r |-> (rel_cnt_r == '0))
    else $error("release countdown nonzero while disarmed");

  a_down_rel: assert property (@(posedge clk) disable iff (!rst_n)
    (down_r & rel_r) == '0)
    else $error("button both down and released");

  for (genvar g = 0; g < BUTTON_SLOTS; g++) begin : g_chk
    a_hold_clicks: assert property (@(posedge clk) disable iff (!rst_n)
      holding_r[g] |-> (click_r[g] == '0))
      else $error("holding button kept a click count");
  end
`endif

endmodule

/* design/bchc_cfg.sv */
module bchc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bchc_pkg::APB_AW-1:0] paddr,
  input  logic [bchc_pkg::APB_DW-1:0] pwdata,
  output logic [bchc_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output bchc_pkg::cfg_t              cfg
);
  import bchc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    unique case (idx)
      REG_DEBOUNCE: begin
        prdata = APB_DW'(cfg_r.debounce_count);
        if (wr_en) cfg_nxt.debounce_count = pwdata[CNT_W-1:0];
      end
      REG_PRESS_LEVEL: begin
        prdata = APB_DW'(cfg_r.press_level);
        if (wr_en) cfg_nxt.press_level = pwdata[0];
      end
      REG_HOLD_PERIOD: begin
        prdata = APB_DW'(cfg_r.hold_period_ticks);
        if (wr_en) cfg_nxt.hold_period_ticks = pwdata[TMR_W-1:0];
      end
      REG_RELEASE_DELAY: begin
        prdata = APB_DW'(cfg_r.release_delay_ticks);
        if (wr_en) cfg_nxt.release_delay_ticks = pwdata[TMR_W-1:0];
      end
      REG_PRESS_LIMIT: begin
        prdata = APB_DW'(cfg_r.press_limit);
        if (wr_en) cfg_nxt.press_limit = pwdata[CNT_W-1:0];
      end
      REG_HOLD_LIMIT: begin
        prdata = APB_DW'(cfg_r.hold_limit);
        if (wr_en) cfg_nxt.hold_limit = pwdata[CNT_W-1:0];
      end
      REG_UNKNOWN_CODE: begin
        prdata = APB_DW'(cfg_r.unknown_code);
        if (wr_en) cfg_nxt.unknown_code = pwdata[CODE_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* design/bchc_ser.sv */
module bchc_ser #(
  parameter  int BUTTON_SLOTS = bchc_pkg::BUTTON_SLOTS_DEF,
  localparam int NSLOT        = 2 * BUTTON_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [NSLOT-1:0]            load_mask,
  input  logic [bchc_pkg::CODE_W-1:0] load_code [NSLOT],
  output logic                        free,
  bchc_out_if.source                  out_ch
);
  import bchc_pkg::*;

  logic [NSLOT-1:0]  mask_r;
  logic [NSLOT-1:0]  mask_nxt;
  logic [CODE_W-1:0] code_r [NSLOT];
  logic              out_v_r;
  report_kind_t      kind_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CODE_W-1:0] ocode_r;
  logic              last_r;

  logic [NSLOT-1:0]  sel_oh;
  logic [NSLOT-1:0]  rest;
  report_kind_t      sel_kind;
  logic [IDX_W-1:0]  sel_idx;
  logic [CODE_W-1:0] sel_code;
  logic              pop;

  // lowest pending slot goes first: hold reports by button, then final reports
  always_comb begin
    sel_oh   = '0;
    sel_kind = KIND_HOLD;
    sel_idx  = '0;
    sel_code = '0;
    for (int k = NSLOT - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        sel_oh   = NSLOT'(1) << k;
        sel_kind = (k >= BUTTON_SLOTS) ? KIND_FINAL : KIND_HOLD;
        sel_idx  = (k >= BUTTON_SLOTS) ? IDX_W'(k - BUTTON_SLOTS) : IDX_W'(k);
        sel_code = code_r[k];
      end
    end
  end

  assign rest     = mask_r & ~sel_oh;
  assign pop      = (mask_r != '0) && (!out_v_r || out_ch.ready);
  assign free     = (mask_r == '0) || (pop && (rest == '0));
  assign mask_nxt = load ? load_mask : (pop ? rest : mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (pop) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= load_code;
    end
    if (pop) begin
      kind_r  <= sel_kind;
      idx_r   <= sel_idx;
      ocode_r <= sel_code;
      last_r  <= (rest == '0);
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.report_kind  = kind_r;
  assign out_ch.button_index = idx_r;
  assign out_ch.report_code  = ocode_r;
  assign out_ch.last         = last_r;

endmodule

/* bench/bchc_report_checker.sv */
`timescale 1ns / 1ps
module bchc_report_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  bchc_in_if                          in_mon,
  bchc_out_if                         out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [bchc_pkg::APB_AW-1:0] paddr,
  input  logic [bchc_pkg::APB_DW-1:0] pwdata,
  output int                          errors,
  output int                          outstanding
);
  import bchc_pkg::*;

  localparam int NB = BUTTON_SLOTS_DEF;

  typedef struct packed {
    report_kind_t      kind;
    logic [IDX_W-1:0]  button;
    logic [CODE_W-1:0] code;
    logic              last;
  } report_t;

  cfg_t             cfg;
  logic             cand_lvl [NB];
  logic             acc_lvl  [NB];
  logic [CNT_W-1:0] stable   [NB];
  bit               down     [NB];
  bit               released [NB];
  bit               holding  [NB];
  logic [CNT_W-1:0] clicks   [NB];
  logic [TMR_W-1:0] steps    [NB];
  logic [TMR_W-1:0] hold_cd;
  logic [TMR_W-1:0] release_cd;
  bit               hold_armed;
  bit               release_armed;
  report_t          expected_reports [$];

  function automatic logic [31:0] hold_level(input logic [TMR_W-1:0] n);
    return 32'(n / TMR_W'(HOLD_STEP_UNIT)) + 32'(cfg.press_limit);
  endfunction

  task automatic reset_model();
    int i;
    cfg = CFG_RST;
    for (i = 0; i < NB; i++) begin
      cand_lvl[i] = IDLE_LEVEL_RST;
      acc_lvl[i]  = IDLE_LEVEL_RST;
      stable[i]   = '0;
      down[i]     = 1'b0;
      released[i] = 1'b0;
      holding[i]  = 1'b0;
      clicks[i]   = '0;
      steps[i]    = '0;
    end
    hold_cd       = '0;
    hold_armed    = 1'b0;
    release_cd    = '0;
    release_armed = 1'b0;
    expected_reports.delete();
  endtask

  task automatic classify_tick(input logic [RAW_W-1:0] raw);
    report_t     found [$];
    bit          any_down;
    bit          fire;
    logic [31:0] c;
    int          i;

    // hold timer
    fire = 1'b0;
    if (hold_armed) begin
      if (hold_cd <= 1) begin
        hold_armed = 1'b0;
        hold_cd    = '0;
        fire       = 1'b1;
      end else begin
        hold_cd = hold_cd - 1'b1;
      end
    end
    if (fire) begin
      any_down = 1'b0;
      for (i = 0; i < NB; i++) begin
        if (down[i]) begin
          any_down = 1'b1;
          if (steps[i] != '1)
            steps[i] = steps[i] + 1'b1;
          if (steps[i] >= HOLD_STEP_UNIT) begin
            holding[i] = 1'b1;
            clicks[i]  = '0;
          end
          if (steps[i] % HOLD_STEP_UNIT == 0) begin
            c = hold_level(steps[i]);
            if (c > 255)
              c = 255;
            if (found.size() < MAX_REPORTS)
              found.push_back('{kind: KIND_HOLD, button: IDX_W'(i), code: CODE_W'(c),
                                last: 1'b0});
          end
        end
      end
      if (any_down) begin
        hold_armed = 1'b1;
        hold_cd    = (cfg.hold_period_ticks == 0) ? TMR_W'(1) : cfg.hold_period_ticks;
      end
    end

    // release timer
    fire = 1'b0;
    if (release_armed) begin
      if (release_cd <= 1) begin
        release_armed = 1'b0;
        release_cd    = '0;
        fire          = 1'b1;
      end else begin
        release_cd = release_cd - 1'b1;
      end
    end
    if (fire) begin
      for (i = 0; i < NB; i++) begin
        if (released[i]) begin
          if (!holding[i]) begin
            c = (clicks[i] >= cfg.press_limit) ? 32'(cfg.unknown_code) : 32'(clicks[i]);
          end else begin
            c = hold_level(steps[i]);
            if (c >= 32'(cfg.hold_limit))
              c = 32'(cfg.unknown_code);
          end
          if (found.size() < MAX_REPORTS)
            found.push_back('{kind: KIND_FINAL, button: IDX_W'(i), code: CODE_W'(c),
                              last: 1'b0});
          steps[i]    = '0;
          clicks[i]   = '0;
          down[i]     = 1'b0;
          released[i] = 1'b0;
          holding[i]  = 1'b0;
        end
      end
    end

    // debounce, press and release
    for (i = 0; i < NB; i++) begin
      if (raw[i] != cand_lvl[i]) begin
        cand_lvl[i] = raw[i];
        stable[i]   = CNT_W'(1);
      end else if (stable[i] != '1) begin
        stable[i] = stable[i] + 1'b1;
      end
      if (stable[i] >= cfg.debounce_count && cand_lvl[i] != acc_lvl[i]) begin
        acc_lvl[i] = cand_lvl[i];
        if (acc_lvl[i] == cfg.press_level) begin
          if (clicks[i] != '1)
            clicks[i] = clicks[i] + 1'b1;
          if (!down[i]) begin
            hold_armed = 1'b1;
            hold_cd    = TMR_W'(1);
          end
          holding[i]  = 1'b0;
          steps[i]    = '0;
          down[i]     = 1'b1;
          released[i] = 1'b0;
        end else begin
          released[i]   = 1'b1;
          down[i]       = 1'b0;
          release_armed = 1'b1;
          release_cd    = (cfg.release_delay_ticks == 0) ? TMR_W'(1)
                                                         : cfg.release_delay_ticks;
        end
      end
    end

    if (found.size() > 0)
      found[found.size() - 1].last = 1'b1;
    foreach (found[k])
      expected_reports.push_back(found[k]);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_report();
    report_t want;
    if (expected_reports.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, actual kind=%0d button=%0d code=%0d last=%0d",
               $time, out_mon.report_kind, out_mon.button_index, out_mon.report_code,
               out_mon.last);
    end else begin
      want = expected_reports.pop_front();
      compare_field("report_kind", 32'(want.kind), 32'(out_mon.report_kind));
      compare_field("button_index", 32'(want.button), 32'(out_mon.button_index));
      compare_field("report_code", 32'(want.code), 32'(out_mon.report_code));
      compare_field("last", 32'(want.last), 32'(out_mon.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_DEBOUNCE:      cfg.debounce_count      = pwdata[CNT_W-1:0];
          REG_PRESS_LEVEL:   cfg.press_level         = pwdata[0];
          REG_HOLD_PERIOD:   cfg.hold_period_ticks   = pwdata[TMR_W-1:0];
          REG_RELEASE_DELAY: cfg.release_delay_ticks = pwdata[TMR_W-1:0];
          REG_PRESS_LIMIT:   cfg.press_limit         = pwdata[CNT_W-1:0];
          REG_HOLD_LIMIT:    cfg.hold_limit          = pwdata[CNT_W-1:0];
          REG_UNKNOWN_CODE:  cfg.unknown_code        = pwdata[CODE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        classify_tick(in_mon.raw_levels);
      if (out_mon.valid && out_mon.ready)
        check_report();
    end
    outstanding <= expected_reports.size();
  end

endmodule

/* bench/button_click_hold_classifier_tb.sv */
`timescale 1ns / 1ps
module button_click_hold_classifier_tb;
  import bchc_pkg::*;

  localparam logic [RAW_W-1:0] DIRECTED_TICKS [25] = '{
    4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hF, 4'hE,
    4'hF, 4'hE, 4'hF, 4'hE, 4'hF, 4'hF, 4'hF, 4'hF, 4'h7, 4'hF,
    4'h7, 4'hF, 4'hF, 4'hF, 4'hF
  };

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int               errors;
  int               outstanding;
  int               reports_seen;
  int               idle_pct;
  int               stall_pct;
  logic             hold_off;
  logic             hold_off_go;
  logic [RAW_W-1:0] levels;
  int               run_left [RAW_W];
  cfg_t             phase_cfg;

  bchc_in_if  in_ch ();
  bchc_out_if out_ch ();

  button_click_hold_classifier dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bchc_report_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      reports_seen <= reports_seen + 1;
  end

  // long receiver hold-off while ticks keep coming
  initial begin
    hold_off = 1'b0;
    wait (hold_off_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic set_pace(input int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 50; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 50; end
      default: begin idle_pct = 31; stall_pct = 31; end
    endcase
  endtask

  task automatic send_tick(input logic [RAW_W-1:0] raw);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_levels <= raw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(REG_DEBOUNCE, APB_DW'(c.debounce_count));
    write_reg(REG_PRESS_LEVEL, APB_DW'(c.press_level));
    write_reg(REG_HOLD_PERIOD, APB_DW'(c.hold_period_ticks));
    write_reg(REG_RELEASE_DELAY, APB_DW'(c.release_delay_ticks));
    write_reg(REG_PRESS_LIMIT, APB_DW'(c.press_limit));
    write_reg(REG_HOLD_LIMIT, APB_DW'(c.hold_limit));
    write_reg(REG_UNKNOWN_CODE, APB_DW'(c.unknown_code));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // per-button level runs: bounces up to the debounce count long, clicks and holds
  task automatic random_ticks(input int count);
    int               n;
    int               b;
    int               dbc;
    int               span;
    logic [RAW_W-1:0] raw;
    dbc  = phase_cfg.debounce_count;
    span = dbc + 7 * int'(phase_cfg.hold_period_ticks) + 4;
    if (span > 60)
      span = 60;
    for (n = 0; n < count; n++) begin
      for (b = 0; b < RAW_W; b++) begin
        if (run_left[b] == 0) begin
          levels[b] = ~levels[b];
          if ($urandom_range(0, 99) < 30)
            run_left[b] = $urandom_range(1, dbc);
          else
            run_left[b] = $urandom_range(dbc, span);
        end
        run_left[b]--;
      end
      raw = ($urandom_range(0, 9) == 0) ? RAW_W'($urandom_range(0, 15)) : levels;
      send_tick(raw);
    end
  endtask

  initial begin
    int p;
    int extra;
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.raw_levels <= '0;
    hold_off_go      = 1'b0;
    levels           = '1;
    foreach (run_left[b])
      run_left[b] = 0;
    set_pace(0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    phase_cfg = '{debounce_count: 8'd1, press_level: 1'b0, hold_period_ticks: 16'd1,
                  release_delay_ticks: 16'd3, press_limit: 8'd3, hold_limit: 8'd6,
                  unknown_code: 8'hAA};
    load_cfg(phase_cfg);
    foreach (DIRECTED_TICKS[k])
      send_tick(DIRECTED_TICKS[k]);
    levels      = DIRECTED_TICKS[24];
    hold_off_go = 1'b1;
    random_ticks(25);
    settle();

    phase_cfg = '{debounce_count: 8'd2, press_level: 1'b1, hold_period_ticks: 16'd2,
                  release_delay_ticks: 16'd3, press_limit: 8'd255, hold_limit: 8'd255,
                  unknown_code: 8'h00};
    load_cfg(phase_cfg);
    set_pace(1);
    random_ticks(25);
    settle();

    // long periods: a full debounce window pressed, then released
    phase_cfg = '{debounce_count: 8'd30, press_level: 1'b1, hold_period_ticks: 16'hFFFF,
                  release_delay_ticks: 16'hFFFF, press_limit: 8'd1, hold_limit: 8'd1,
                  unknown_code: 8'h5A};
    load_cfg(phase_cfg);
    set_pace(2);
    repeat (32) send_tick(4'hF);
    repeat (32) send_tick(4'h0);
    settle();

    for (p = 3; p < 6; p++) begin
      phase_cfg.debounce_count      = CNT_W'($urandom_range(1, 4));
      phase_cfg.press_level         = 1'($urandom_range(0, 1));
      phase_cfg.hold_period_ticks   = TMR_W'($urandom_range(1, 4));
      phase_cfg.release_delay_ticks = TMR_W'($urandom_range(1, 8));
      phase_cfg.press_limit         = CNT_W'($urandom_range(1, 8));
      phase_cfg.hold_limit          = CNT_W'($urandom_range(1, 20));
      phase_cfg.unknown_code        = CODE_W'($urandom_range(0, 255));
      load_cfg(phase_cfg);
      set_pace(p);
      random_ticks(20);
      if (p == 5) begin
        extra = 0;
        while (reports_seen < 60 && extra < 2) begin
          random_ticks(5);
          extra++;
        end
      end
      settle();
    end

    if (errors == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
